/* rtl/vln_pkg.sv */
`default_nettype none
package vln_pkg;

    localparam int CompWidth  = 16;
    localparam int SumWidth   = 33;
    localparam int MagWidth   = 17;
    localparam int UnitWidth  = 16;
    localparam int FracBits   = 14;
    localparam int NumComp    = 4;
    // Root digits produced: one per pair of sum bits.
    localparam int RootSteps  = MagWidth;
    // Quotient of |c| << 14 by the magnitude fits 15 bits.
    localparam int QuoWidth   = 15;
    localparam int DivWidth   = CompWidth + FracBits;
    localparam int FifoDepth  = 4;
    localparam int FifoAw     = 2;

    typedef logic [CompWidth-1:0] comp_t;

    // Item passed from the front part to the back part.
    typedef struct packed {
        logic [SumWidth-1:0]                 sum;
        logic [NumComp-1:0][CompWidth-1:0]   mag_c;
        logic [NumComp-1:0]                  neg;
    } front_item_t;

endpackage
`default_nettype wire

/* rtl/vln_front.sv */
`default_nettype none
module vln_front
    import vln_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [63:0] in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output front_item_t      out_item
);

    logic [NumComp-1:0][CompWidth-1:0] sq_mag_reg;
    logic [NumComp-1:0]                sq_neg_reg;
    logic [NumComp-1:0][31:0]          sq_reg;
    logic                              s1_valid_reg;
    logic                              s2_valid_reg;
    front_item_t                       item_reg;
    logic                              adv;

    assign adv       = !s2_valid_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = s2_valid_reg;
    assign out_item  = item_reg;

    // Valid flags of the two front stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Stage one: absolute values and squares; stage two: the sum.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NumComp; i++)
            begin
                sq_neg_reg[i] <= in_data[16*i+15];
                sq_mag_reg[i] <= in_data[16*i+15] ? 16'(-in_data[16*i +: 16])
                                                  : in_data[16*i +: 16];
                sq_reg[i] <= 32'($signed(in_data[16*i +: 16])
                               * $signed(in_data[16*i +: 16]));
            end
            item_reg.sum   <= {1'b0, sq_reg[0]} + {1'b0, sq_reg[1]}
                            + {1'b0, sq_reg[2]} + {1'b0, sq_reg[3]};
            item_reg.mag_c <= sq_mag_reg;
            item_reg.neg   <= sq_neg_reg;
        end
    end

endmodule
`default_nettype wire

/* rtl/vln_fifo.sv */
`default_nettype none
module vln_fifo
    import vln_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   wr_valid,
    output logic        wr_ready,
    input  front_item_t wr_item,
    output logic        rd_valid,
    input  wire logic   rd_ready,
    output front_item_t rd_item
);

    front_item_t       mem_reg [FifoDepth];
    logic [FifoAw-1:0] wptr_reg;
    logic [FifoAw-1:0] rptr_reg;
    logic [FifoAw:0]   count_reg;
    logic              wr_en;
    logic              rd_en;

    assign wr_ready = (count_reg != (FifoAw+1)'(FifoDepth));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem_reg[rptr_reg];
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wptr_reg <= wptr_reg + 1'b1;
            if (rd_en)
                rptr_reg <= rptr_reg + 1'b1;
            count_reg <= count_reg + (FifoAw+1)'(wr_en) - (FifoAw+1)'(rd_en);
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wptr_reg] <= wr_item;
    end

endmodule
`default_nettype wire

/* rtl/vln_back.sv */
`default_nettype none
module vln_back
    import vln_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  front_item_t       in_item,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [87:0]       out_data
);

    localparam int SqStages  = RootSteps;
    localparam int DivStages = QuoWidth;
    localparam int Total     = SqStages + DivStages;
    localparam int RemW      = MagWidth + 2;
    // Radicand widened to a whole number of bit pairs.
    localparam int RootInW   = 2 * SqStages;

    // Square-root pipeline state: the entry slot and one slot per stage.
    logic [SqStages:0][RootInW-1:0]               sq_n_reg;
    logic [SqStages:0][MagWidth-1:0]              sq_root_reg;
    logic [SqStages:0][RemW-1:0]                  sq_rem_reg;
    logic [SqStages:0][NumComp-1:0][CompWidth-1:0] sq_c_reg;
    logic [SqStages:0][NumComp-1:0]               sq_neg_reg;
    // Divider pipeline state.
    logic [DivStages:0][MagWidth-1:0]              dv_mag_reg;
    logic [DivStages:0][NumComp-1:0][DivWidth-1:0] dv_num_reg;
    logic [DivStages:0][NumComp-1:0][MagWidth:0]   dv_rem_reg;
    logic [DivStages:0][NumComp-1:0][QuoWidth-1:0] dv_q_reg;
    logic [DivStages:0][NumComp-1:0]               dv_neg_reg;
    logic [Total-1:0]                              valid_reg;
    logic                                          adv;
    logic [87:0]                                   res;

    assign adv       = !valid_reg[Total-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = valid_reg[Total-1];
    assign out_data  = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[Total-2:0], in_valid};
    end

    // Stage entry.
    always_comb
    begin
        sq_n_reg[0]    = {1'b0, in_item.sum};
        sq_root_reg[0] = '0;
        sq_rem_reg[0]  = '0;
        sq_c_reg[0]    = in_item.mag_c;
        sq_neg_reg[0]  = in_item.neg;
    end

    // Restoring square root: one root bit per stage.
    for (genvar s = 0; s < SqStages; s++)
    begin : g_sqrt
        logic [RemW-1:0]    trial_rem;
        logic [RemW-1:0]    trial;
        logic [RootInW-1:0] n_shift;
        always_comb
        begin
            trial_rem = {sq_rem_reg[s][RemW-3:0], sq_n_reg[s][RootInW-1 -: 2]};
            trial     = {sq_root_reg[s], 2'b01};
            n_shift   = {sq_n_reg[s][RootInW-3:0], 2'b00};
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_n_reg[s+1]   <= n_shift;
                sq_c_reg[s+1]   <= sq_c_reg[s];
                sq_neg_reg[s+1] <= sq_neg_reg[s];
                if (trial_rem >= trial)
                begin
                    sq_rem_reg[s+1]  <= trial_rem - trial;
                    sq_root_reg[s+1] <= {sq_root_reg[s][MagWidth-2:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg[s+1]  <= trial_rem;
                    sq_root_reg[s+1] <= {sq_root_reg[s][MagWidth-2:0], 1'b0};
                end
            end
        end
    end

    // Divider entry: the numerator is |c| << 14. Its upper bits, |c| >> 1,
    // are already below the magnitude, so they start as the partial
    // remainder and only the low 15 numerator bits are left to shift in.
    always_comb
    begin
        dv_mag_reg[0] = sq_root_reg[SqStages];
        dv_neg_reg[0] = sq_neg_reg[SqStages];
        for (int i = 0; i < NumComp; i++)
        begin
            dv_num_reg[0][i] = {sq_c_reg[SqStages][i][0], (DivWidth-1)'(0)};
            dv_rem_reg[0][i] = (MagWidth+1)'(sq_c_reg[SqStages][i][CompWidth-1:1]);
            dv_q_reg[0][i]   = '0;
        end
    end

    // Restoring division: one quotient bit per stage for each lane.
    for (genvar s = 0; s < DivStages; s++)
    begin : g_div
        for (genvar i = 0; i < NumComp; i++)
        begin : g_lane
            logic [MagWidth:0] part;
            always_comb
                part = {dv_rem_reg[s][i][MagWidth-1:0],
                        dv_num_reg[s][i][DivWidth-1]};
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dv_num_reg[s+1][i] <= {dv_num_reg[s][i][DivWidth-2:0], 1'b0};
                    if (part >= {1'b0, dv_mag_reg[s]})
                    begin
                        dv_rem_reg[s+1][i] <= part - {1'b0, dv_mag_reg[s]};
                        dv_q_reg[s+1][i]   <= {dv_q_reg[s][i][QuoWidth-2:0], 1'b1};
                    end
                    else
                    begin
                        dv_rem_reg[s+1][i] <= part;
                        dv_q_reg[s+1][i]   <= {dv_q_reg[s][i][QuoWidth-2:0], 1'b0};
                    end
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_mag_reg[s+1] <= dv_mag_reg[s];
                dv_neg_reg[s+1] <= dv_neg_reg[s];
            end
        end
    end

    // Result packing.
    always_comb
    begin
        logic zero;
        logic [NumComp-1:0][UnitWidth-1:0] u;
        zero = (dv_mag_reg[DivStages] == '0);
        for (int i = 0; i < NumComp; i++)
        begin
            u[i] = {1'b0, dv_q_reg[DivStages][i]};
            if (zero)
                u[i] = '0;
            else if (dv_neg_reg[DivStages][i])
                u[i] = -u[i];
        end
        res = {6'b0, zero, u[3], u[2], u[1], u[0], dv_mag_reg[DivStages]};
    end

endmodule
`default_nettype wire

/* rtl/vector_length_normalize_core.sv */
// Pipeline: the front squares and sum, a queue, then the square-root and divide stages.
// Throughput: one vector per cycle unless the output stalls; sqrt and divide are fully pipelined, one bit a stage.
// Reset (rst_n, asynchronous, active low) clears all valid flags and queue pointers.
// The output holds until taken; each part stalls on its own behind the queue.
`default_nettype none
module vector_length_normalize_core
    import vln_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // comp_x, comp_y, comp_z, comp_w
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata    // magnitude, unit_x..unit_w, zero_vector, pad
);

    logic        f_valid;
    logic        f_ready;
    front_item_t f_item;
    logic        q_valid;
    logic        q_ready;
    front_item_t q_item;

    vln_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
        .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
    );

    vln_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
    );

    vln_back u_back (
        .clk(clk), .rst_n(rst_n),
        .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata)
    );

endmodule
`default_nettype wire

/* dv/vln_checker.sv */
`timescale 1ns / 100ps
`default_nettype none
module vln_checker
    import vln_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [63:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [87:0] m_tdata,
    output int               fail_count,
    output int               pending,
    output int               vectors_seen,
    output int               zero_seen
);

    typedef struct packed {
        logic [16:0] magnitude;
        logic [15:0] unit_x;
        logic [15:0] unit_y;
        logic [15:0] unit_z;
        logic [15:0] unit_w;
        logic        zero_vector;
    } norm_t;

    norm_t expected_norms[$];

    // Truncated integer square root, one result bit at a time.
    function automatic logic [16:0] floor_root(input logic [32:0] n);
        logic [16:0] r;
        logic [16:0] trial;
        r = '0;
        for (int b = 16; b >= 0; b--)
        begin
            trial = r | (17'd1 << b);
            if ({17'd0, trial} * {17'd0, trial} <= {1'b0, n})
                r = trial;
        end
        return r;
    endfunction

    // Component scaled to Q1.14 by the length, rounded toward zero.
    function automatic logic [15:0] scale_unit(input logic signed [15:0] c,
                                               input logic [16:0] mag);
        logic [31:0] a;
        logic [31:0] q;
        if (mag == 0)
            return '0;
        a = (c < 0) ? 32'(-32'(c)) : 32'(c);
        q = (a << FracBits) / mag;
        if (c < 0)
            q = -q;
        return q[15:0];
    endfunction

    function automatic norm_t normalize(input logic [63:0] beat);
        norm_t r;
        logic [32:0] sum;
        logic signed [15:0] c[4];
        int sq;
        sum = '0;
        for (int i = 0; i < 4; i++)
        begin
            c[i] = beat[16*i +: 16];
            sq   = int'(c[i]) * int'(c[i]);
            sum += 33'(sq);
        end
        r.magnitude   = floor_root(sum);
        r.unit_x      = scale_unit(c[0], r.magnitude);
        r.unit_y      = scale_unit(c[1], r.magnitude);
        r.unit_z      = scale_unit(c[2], r.magnitude);
        r.unit_w      = scale_unit(c[3], r.magnitude);
        r.zero_vector = (r.magnitude == 0);
        return r;
    endfunction

    task automatic compare(input string name, input logic [16:0] exp_v,
                           input logic [16:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count   = 0;
        pending      = 0;
        vectors_seen = 0;
        zero_seen    = 0;
    end

    // Predict on every accepted input beat, check every accepted output beat.
    always @(posedge clk)
    begin
        norm_t got;
        norm_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                expected_norms.push_back(normalize(s_tdata));
                vectors_seen++;
            end
            if (m_tvalid && m_tready)
            begin
                got.magnitude   = m_tdata[16:0];
                got.unit_x      = m_tdata[32:17];
                got.unit_y      = m_tdata[48:33];
                got.unit_z      = m_tdata[64:49];
                got.unit_w      = m_tdata[80:65];
                got.zero_vector = m_tdata[81];
                if (expected_norms.size() == 0)
                begin
                    $error("output beat with no vector outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_norms.pop_front();
                    if (want.zero_vector)
                        zero_seen++;
                    compare("magnitude", want.magnitude, got.magnitude);
                    compare("unit_x", 17'(want.unit_x), 17'(got.unit_x));
                    compare("unit_y", 17'(want.unit_y), 17'(got.unit_y));
                    compare("unit_z", 17'(want.unit_z), 17'(got.unit_z));
                    compare("unit_w", 17'(want.unit_w), 17'(got.unit_w));
                    compare("zero_vector", 17'(want.zero_vector),
                            17'(got.zero_vector));
                end
            end
            pending = expected_norms.size();
        end
    end

endmodule
`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;
    int          fail_count;
    int          pending;
    int          vectors_seen;
    int          zero_seen;
    bit          idle_enable;

    vector_length_normalize_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    vln_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .vectors_seen (vectors_seen),
        .zero_seen    (zero_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("vector_length_normalize_core verification failed");
        $finish;
    end

    // Output side stalls in random bursts while idling is enabled.
    initial
    begin
        int burst;
        m_tready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (idle_enable && $urandom_range(0, 3) == 0)
            begin
                burst = $urandom_range(1, 10);
                m_tready <= 1'b0;
                repeat (burst) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    function automatic logic [15:0] random_comp();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'($urandom_range(0, 7)) - 16'd3;
            3:       return '0;
            default: return 16'($urandom);
        endcase
    endfunction

    // Present one vector and hold it until it is taken.
    task automatic send_vector(input logic [63:0] v);
        int burst;
        if (idle_enable && $urandom_range(0, 4) == 0)
        begin
            burst = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (burst) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(posedge clk iff s_tready);
    endtask

    initial
    begin
        logic [63:0] directed[$];
        int wait_cycles;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        rst_n       = 1'b0;
        idle_enable = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero vector, extremes, mixed signs, 2D and 3D shapes, single axes.
        directed = '{64'h0, {4{16'h8000}}, {4{16'h7FFF}}, {4{16'hFFFF}},
                     {4{16'h0001}}, 64'h0000_0000_0000_8000,
                     64'h0000_0000_7FFF_0000, 64'h0000_8000_0000_0000,
                     64'h7FFF_0000_0000_0000, 64'h0000_0000_0400_0300,
                     64'h0000_FB00_FC00_0300, 64'h8000_7FFF_8000_7FFF,
                     64'h0000_0000_FFFF_0001, 64'hAAAA_5555_AAAA_5555,
                     64'h5555_AAAA_5555_AAAA, 64'h0000_0000_0000_0001};
        foreach (directed[i])
            send_vector(directed[i]);

        // Hold off until every outstanding vector has come back.
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);

        for (int n = 0; n < 500; n++)
        begin
            if (n == 420)
                idle_enable = 1'b0;
            send_vector({random_comp(), random_comp(), random_comp(), random_comp()});
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        wait_cycles = 0;
        while (wait_cycles < 100)
        begin
            @(posedge clk);
            wait_cycles++;
        end

        $display("Normalized %0d vectors, %0d of them zero, with random stalls on both sides.",
                 vectors_seen, zero_seen);
        if (fail_count == 0)
            $display("vector_length_normalize_core verification clean");
        else
            $display("vector_length_normalize_core verification failed");
        $finish;
    end

endmodule
`default_nettype wire

/* sim.f */
rtl/vln_pkg.sv
rtl/vln_front.sv
rtl/vln_fifo.sv
rtl/vln_back.sv
rtl/vector_length_normalize_core.sv
dv/vln_checker.sv
dv/tb.sv
